@@ hw/rtl/pbq_pkg.sv @@
`timescale 1ns / 1ps
package pbq_pkg;

  localparam int RIGHT_FRAC = 14;
  localparam logic [16:0] UV_ONE = 17'd65536;
  localparam logic [16:0] UV_HUNDREDTH = 17'd655;
  localparam logic CFG_RIGHT_X = 1'b0;
  localparam logic CFG_RIGHT_Z = 1'b1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        age;
    logic [31:0]        life;
    logic [31:0]        start_color;
    logic [31:0]        end_color;
    logic [30:0]        start_size;
    logic [30:0]        end_size;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [31:0]        vert_color;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               last_vertex;
  } out_item_t;

  // quad center, color and signed corner offsets
  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] color;
    logic [31:0] off_x;
    logic [31:0] off_y;
    logic [31:0] off_z;
  } quad_base_t;

endpackage

@@ hw/rtl/pbq_div.sv @@
`timescale 1ns / 1ps
module pbq_div import pbq_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output in_item_t             out_item,
  output logic [FRAC_BITS:0]   out_t
);

  localparam int NS = FRAC_BITS + 1;

  logic [NS-1:0]          vld_r;
  logic [NS-1:0]          dead_r;
  in_item_t               item_r [NS];
  logic [31:0]            rem_r  [NS];
  logic [FRAC_BITS-1:0]   q_r    [NS];

  // load: remainder starts at age since age < life for a live particle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
    item_r[0] <= in_item;
    rem_r[0]  <= in_item.age;
    q_r[0]    <= '0;
    dead_r[0] <= (in_item.life == 32'd0) || (in_item.age >= in_item.life);
  end

  // one quotient bit per stage
  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_step
    logic [32:0] sh;
    logic        ge;
    logic [31:0] nr;
    always_comb begin
      sh = {rem_r[g], 1'b0};
      ge = sh >= {1'b0, item_r[g].life};
      nr = ge ? 32'(sh - {1'b0, item_r[g].life}) : sh[31:0];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
      item_r[g+1] <= item_r[g];
      rem_r[g+1]  <= nr;
      q_r[g+1]    <= {q_r[g][FRAC_BITS-2:0], ge};
      dead_r[g+1] <= dead_r[g];
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_item  = item_r[NS-1];
  assign out_t     = dead_r[NS-1] ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, q_r[NS-1]};

endmodule

@@ hw/rtl/pbq_interp.sv @@
`timescale 1ns / 1ps
module pbq_interp import pbq_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  in_item_t            in_item,
  input  logic [FRAC_BITS:0]  in_t,
  input  logic signed [15:0]  right_x,
  input  logic signed [15:0]  right_z,
  output logic                out_valid,
  output quad_base_t          out_base
);

  localparam int TW  = FRAC_BITS + 1;
  localparam int PW  = 33 + TW + 1;
  localparam int CPW = 9 + TW + 1;

  // stage 1: difference times t
  logic                  v1_r;
  logic signed [PW-1:0]  sprod_r;
  logic signed [CPW-1:0] cprod_r [4];
  logic [30:0]           ss1_r;
  logic [31:0]           sc1_r;
  logic [31:0]           px1_r, py1_r, pz1_r;

  logic signed [32:0] dsz;
  logic signed [8:0]  dc [4];
  always_comb begin
    dsz = $signed({2'b00, in_item.end_size}) - $signed({2'b00, in_item.start_size});
    for (int k = 0; k < 4; k++) begin
      dc[k] = $signed({1'b0, in_item.end_color[k*8 +: 8]})
            - $signed({1'b0, in_item.start_color[k*8 +: 8]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    sprod_r <= PW'(dsz) * $signed({1'b0, in_t});
    for (int k = 0; k < 4; k++) begin
      cprod_r[k] <= CPW'(dc[k]) * $signed({1'b0, in_t});
    end
    ss1_r <= in_item.start_size;
    sc1_r <= in_item.start_color;
    px1_r <= in_item.pos_x;
    py1_r <= in_item.pos_y;
    pz1_r <= in_item.pos_z;
  end

  // stage 2: add start value back, floor by arithmetic shift
  logic        v2_r;
  logic [30:0] size2_r;
  logic [31:0] col2_r;
  logic [31:0] px2_r, py2_r, pz2_r;

  logic signed [PW-1:0]  ssum;
  logic signed [CPW-1:0] csum [4];
  logic [31:0]           col;
  always_comb begin
    ssum = $signed({{(PW-31){1'b0}}, ss1_r}) + (sprod_r >>> FRAC_BITS);
    for (int k = 0; k < 4; k++) begin
      csum[k] = $signed({{(CPW-8){1'b0}}, sc1_r[k*8 +: 8]}) + (cprod_r[k] >>> FRAC_BITS);
      col[k*8 +: 8] = csum[k][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    size2_r <= ssum[30:0];
    col2_r  <= col;
    px2_r <= px1_r;
    py2_r <= py1_r;
    pz2_r <= pz1_r;
  end

  // stage 3: magnitude of right times size
  logic        v3_r;
  logic [31:0] mx3_r, mz3_r;
  logic        nx3_r, nz3_r;
  logic [30:0] size3_r;
  logic [31:0] col3_r;
  logic [31:0] px3_r, py3_r, pz3_r;

  logic [16:0] magx, magz;
  logic [47:0] prx, prz;
  always_comb begin
    magx = right_x[15] ? 17'(-{right_x[15], right_x}) : {1'b0, right_x};
    magz = right_z[15] ? 17'(-{right_z[15], right_z}) : {1'b0, right_z};
    prx  = 48'(magx) * 48'(size2_r);
    prz  = 48'(magz) * 48'(size2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    mx3_r   <= prx[RIGHT_FRAC +: 32];
    mz3_r   <= prz[RIGHT_FRAC +: 32];
    nx3_r   <= right_x[15];
    nz3_r   <= right_z[15];
    size3_r <= size2_r;
    col3_r  <= col2_r;
    px3_r <= px2_r;
    py3_r <= py2_r;
    pz3_r <= pz2_r;
  end

  // stage 4: apply sign, truncation toward zero
  logic       v4_r;
  quad_base_t base4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    base4_r.pos_x <= px3_r;
    base4_r.pos_y <= py3_r;
    base4_r.pos_z <= pz3_r;
    base4_r.color <= col3_r;
    base4_r.off_x <= nx3_r ? 32'(-mx3_r) : mx3_r;
    base4_r.off_z <= nz3_r ? 32'(-mz3_r) : mz3_r;
    base4_r.off_y <= {1'b0, size3_r};
  end

  assign out_valid = v4_r;
  assign out_base  = base4_r;

endmodule

@@ hw/rtl/pbq_emit.sv @@
`timescale 1ns / 1ps
module pbq_emit import pbq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  quad_base_t in_base,
  output logic       out_strobe,
  output out_item_t  out_item
);

  quad_base_t  base_r;
  logic        act_r;
  logic [2:0]  cnt_r;
  logic        strobe_r;
  logic        last_r;
  out_item_t   item_r;

  // hold quad and step through six vertices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= 3'd0;
    end else if (in_valid) begin
      act_r <= 1'b1;
      cnt_r <= 3'd0;
    end else if (act_r) begin
      act_r <= cnt_r != 3'd5;
      cnt_r <= 3'(cnt_r + 3'd1);
    end
    if (in_valid) begin
      base_r <= in_base;
    end
  end

  // corner order p4 p2 p1 p4 p1 p3
  logic        xp, yp;
  logic [16:0] tu, tv;
  always_comb begin
    case (cnt_r)
      3'd0:    begin xp = 1'b0; yp = 1'b0; tu = UV_ONE;       tv = 17'd0;  end
      3'd1:    begin xp = 1'b0; yp = 1'b1; tu = UV_HUNDREDTH; tv = 17'd0;  end
      3'd2:    begin xp = 1'b1; yp = 1'b1; tu = UV_HUNDREDTH; tv = UV_ONE; end
      3'd3:    begin xp = 1'b0; yp = 1'b0; tu = UV_ONE;       tv = 17'd0;  end
      3'd4:    begin xp = 1'b1; yp = 1'b1; tu = UV_HUNDREDTH; tv = UV_ONE; end
      3'd5:    begin xp = 1'b1; yp = 1'b0; tu = UV_ONE;       tv = UV_ONE; end
      default: begin xp = 1'b0; yp = 1'b0; tu = UV_ONE;       tv = 17'd0;  end
    endcase
  end

  // register the vertex, sums wrap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      strobe_r <= act_r;
      last_r   <= act_r && (cnt_r == 3'd5);
    end
    item_r.vert_x <= xp ? base_r.pos_x + base_r.off_x : base_r.pos_x - base_r.off_x;
    item_r.vert_z <= xp ? base_r.pos_z + base_r.off_z : base_r.pos_z - base_r.off_z;
    item_r.vert_y <= yp ? base_r.pos_y + base_r.off_y : base_r.pos_y - base_r.off_y;
    item_r.vert_color  <= base_r.color;
    item_r.tex_u       <= tu;
    item_r.tex_v       <= tv;
    item_r.last_vertex <= 1'b0;
  end

  assign out_strobe = strobe_r;
  always_comb begin
    out_item = item_r;
    out_item.last_vertex = last_r;
  end

endmodule

@@ hw/rtl/particle_billboard_quad_expand.sv @@
`timescale 1ns / 1ps
// Expands one particle into the six vertices of a camera-facing quad. A
// particle is taken when start is high and busy is low; busy then stays high
// for a countdown that matches the time the vertex emitter needs to send its
// six vertices, one per cycle. Results appear on out_item for one cycle each,
// marked by out_strobe, and must be taken as they come: the receiver cannot
// stall. The first vertex leaves after the one-bit-per-stage life fraction
// divider, four interpolation stages and the emitter. The user must write
// the right vector registers only while no particle is in flight; the block
// itself does not enforce it.
module particle_billboard_quad_expand import pbq_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic signed [15:0] right_x_r, right_z_r;
  logic [2:0]         hold_r;
  logic               accept;

  assign accept = start && !busy;
  assign busy   = hold_r != 3'd0;

  // hold off new particles while busy counts down
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 3'd0;
    end else if (accept) begin
      hold_r <= 3'd5;
    end else if (hold_r != 3'd0) begin
      hold_r <= 3'(hold_r - 3'd1);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_x_r <= 16'sd16384;
      right_z_r <= 16'sd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RIGHT_X: right_x_r <= cfg_wdata;
        CFG_RIGHT_Z: right_z_r <= cfg_wdata;
        default:     right_x_r <= right_x_r;
      endcase
    end
  end

  logic                 div_valid;
  in_item_t             div_item;
  logic [FRAC_BITS:0]   div_t;
  logic                 base_valid;
  quad_base_t           base;

  pbq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n),
    .in_valid(accept), .in_item(in_item),
    .out_valid(div_valid), .out_item(div_item), .out_t(div_t)
  );

  pbq_interp #(.FRAC_BITS(FRAC_BITS)) u_interp (
    .clk(clk), .rst_n(rst_n),
    .in_valid(div_valid), .in_item(div_item), .in_t(div_t),
    .right_x(right_x_r), .right_z(right_z_r),
    .out_valid(base_valid), .out_base(base)
  );

  pbq_emit u_emit (
    .clk(clk), .rst_n(rst_n),
    .in_valid(base_valid), .in_base(base),
    .out_strobe(out_strobe), .out_item(out_item)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("busy not raised after accept");
  a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 busy) else $error("busy dropped early");
  a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.last_vertex |-> out_strobe) else $error("last vertex without strobe");
  a_last_then_idle_or_new: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.last_vertex) |=> !out_item.last_vertex)
    else $error("last vertex repeated");
`endif

endmodule
